// ----- rtl/gzhp_pkg.sv -----
package gzhp_pkg;

  localparam logic [1:0] KIND_ENTRY  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_BAD_METH  = 3'd2;
  localparam logic [2:0] ST_BAD_EXTRA = 3'd3;
  localparam logic [2:0] ST_BAD_RA    = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  localparam logic [7:0] MAGIC_ID1   = 8'h1f;
  localparam logic [7:0] MAGIC_ID2   = 8'h8b;
  localparam logic [7:0] METHOD_DEFL = 8'h08;
  localparam logic [7:0] ID_R        = 8'h52;
  localparam logic [7:0] ID_A        = 8'h41;

  localparam int unsigned FLG_HCRC    = 1;
  localparam int unsigned FLG_EXTRA   = 2;
  localparam int unsigned FLG_NAME    = 3;
  localparam int unsigned FLG_COMMENT = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [14:0] entry_index;
    logic [15:0] entry_size;
    logic [31:0] entry_offset;
    logic [31:0] header_length;
    logic [31:0] modified_time;
    logic [15:0] uncompressed_chunk_length;
    logic [14:0] chunk_total;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ----- rtl/gzhp_if.sv -----
interface gzhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface gzhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  status;
  logic [14:0] entry_index;
  logic [15:0] entry_size;
  logic [31:0] entry_offset;
  logic [31:0] header_length;
  logic [31:0] modified_time;
  logic [15:0] uncompressed_chunk_length;
  logic [14:0] chunk_total;

  modport source (
    output valid, output kind, output status, output entry_index, output entry_size,
    output entry_offset, output header_length, output modified_time,
    output uncompressed_chunk_length, output chunk_total, input ready
  );
  modport sink (
    input valid, input kind, input status, input entry_index, input entry_size,
    input entry_offset, input header_length, input modified_time,
    input uncompressed_chunk_length, input chunk_total, output ready
  );
endinterface

// ----- rtl/gzip_header_parser_with_chunk_index_unit.sv -----
// a byte is registered at the input, and its results are then written into the result queue
// one byte per cycle unless stalled; at most two results follow a byte (entry, then verdict)
// the input stage stalls only when the four-deep result queue has fewer than two free slots
// reset (rst_ni low, asynchronous) returns the parser to the first magic byte, clears all
// counters and captured fields, and empties the result queue
module gzip_header_parser_with_chunk_index_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  gzhp_in_if.sink     in_i,
  gzhp_out_if.source  out_o
);

  gzhp_pkg::push_t push;
  logic            room;

  gzhp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  gzhp_res_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

// ----- rtl/gzhp_parser.sv -----
module gzhp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  gzhp_in_if.sink           in_i,
  input  logic              room_i,
  output gzhp_pkg::push_t   push_o
);

  localparam logic [3:0] PH_MAGIC1  = 4'd0;
  localparam logic [3:0] PH_MAGIC2  = 4'd1;
  localparam logic [3:0] PH_METHOD  = 4'd2;
  localparam logic [3:0] PH_FLAGS   = 4'd3;
  localparam logic [3:0] PH_MTIME   = 4'd4;
  localparam logic [3:0] PH_XFLOS   = 4'd5;
  localparam logic [3:0] PH_XLEN    = 4'd6;
  localparam logic [3:0] PH_SUBHDR  = 4'd7;
  localparam logic [3:0] PH_RAHDR   = 4'd8;
  localparam logic [3:0] PH_RACHUNK = 4'd9;
  localparam logic [3:0] PH_SKIP    = 4'd10;
  localparam logic [3:0] PH_NAME    = 4'd11;
  localparam logic [3:0] PH_COMMENT = 4'd12;
  localparam logic [3:0] PH_HCRC    = 4'd13;
  localparam logic [3:0] PH_DONE    = 4'd14;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_eoi_q;
  logic        take;

  logic [3:0]  phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [4:0]  flags_q, flags_d;
  logic [15:0] extra_q, extra_d;
  logic [15:0] sub_q, sub_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] ra_ver_q, ra_ver_d;
  logic [31:0] length_q, length_d;
  logic [31:0] time_q, time_d;
  logic [15:0] clen_q, clen_d;
  logic [14:0] ccnt_q, ccnt_d;
  logic [14:0] entry_q, entry_d;
  logic [31:0] off_q, off_d;

  logic [15:0] word_v;
  logic        go_xnext, go_sec, rej;
  logic [2:0]  sec_from;
  logic [2:0]  rej_code;
  logic [1:0]  res_cnt;
  gzhp_pkg::res_t res0, res1, res_new;

  assign take        = in_vld_q && room_i;
  assign in_i.ready  = !in_vld_q || room_i;
  assign word_v      = {in_byte_q, hold_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_eoi_q  <= in_i.end_of_input;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    flags_d  = flags_q;
    extra_d  = extra_q;
    sub_d    = sub_q;
    id_d     = id_q;
    hold_d   = hold_q;
    ra_ver_d = ra_ver_q;
    length_d = length_q;
    time_d   = time_q;
    clen_d   = clen_q;
    ccnt_d   = ccnt_q;
    entry_d  = entry_q;
    off_d    = off_q;
    go_xnext = 1'b0;
    go_sec   = 1'b0;
    sec_from = 3'd0;
    rej      = 1'b0;
    rej_code = gzhp_pkg::ST_OK;
    res_cnt  = 2'd0;
    res0     = '0;
    res1     = '0;
    res_new  = '0;

    if (take && phase_q != PH_DONE) begin
      if (in_eoi_q) begin
        rej      = 1'b1;
        rej_code = gzhp_pkg::ST_TRUNC;
      end else begin
        if (length_q != 32'hffff_ffff) begin
          length_d = length_q + 32'd1;
        end
        case (phase_q)
          PH_MAGIC1: begin
            if (in_byte_q != gzhp_pkg::MAGIC_ID1) begin
              rej = 1'b1; rej_code = gzhp_pkg::ST_BAD_MAGIC;
            end else begin
              phase_d = PH_MAGIC2;
            end
          end
          PH_MAGIC2: begin
            if (in_byte_q != gzhp_pkg::MAGIC_ID2) begin
              rej = 1'b1; rej_code = gzhp_pkg::ST_BAD_MAGIC;
            end else begin
              phase_d = PH_METHOD;
            end
          end
          PH_METHOD: begin
            if (in_byte_q != gzhp_pkg::METHOD_DEFL) begin
              rej = 1'b1; rej_code = gzhp_pkg::ST_BAD_METH;
            end else begin
              phase_d = PH_FLAGS;
            end
          end
          PH_FLAGS: begin
            if (in_byte_q[7:5] != 3'd0) begin
              rej = 1'b1; rej_code = gzhp_pkg::ST_BAD_METH;
            end else begin
              flags_d = in_byte_q[4:0];
              phase_d = PH_MTIME;
              pos_d   = 3'd0;
            end
          end
          PH_MTIME: begin
            if (pos_q == 3'd0) begin
              time_d = {24'd0, in_byte_q};
            end else begin
              time_d = time_q | ({24'd0, in_byte_q} << {pos_q[1:0], 3'b000});
            end
            if (pos_q >= 3'd3) begin
              phase_d = PH_XFLOS;
              pos_d   = 3'd0;
            end else begin
              pos_d = pos_q + 3'd1;
            end
          end
          PH_XFLOS: begin
            if (pos_q == 3'd0) begin
              pos_d = 3'd1;
            end else begin
              go_sec = 1'b1; sec_from = 3'd0;
            end
          end
          PH_XLEN: begin
            if (pos_q == 3'd0) begin
              hold_d = in_byte_q;
              pos_d  = 3'd1;
            end else begin
              extra_d  = word_v;
              go_xnext = 1'b1;
            end
          end
          PH_SUBHDR: begin
            extra_d = extra_q - 16'd1;
            pos_d   = pos_q + 3'd1;
            case (pos_q)
              3'd0: id_d = in_byte_q;
              3'd1: id_d = (id_q == gzhp_pkg::ID_R && in_byte_q == gzhp_pkg::ID_A) ? 8'd1 : 8'd0;
              3'd2: hold_d = in_byte_q;
              default: begin
                pos_d = 3'd0;
                if (word_v > extra_d) begin
                  rej = 1'b1; rej_code = gzhp_pkg::ST_BAD_EXTRA;
                end else begin
                  sub_d = word_v;
                  if (id_q == 8'd1) begin
                    if (word_v < 16'd6) begin
                      rej = 1'b1; rej_code = gzhp_pkg::ST_BAD_RA;
                    end else begin
                      phase_d  = PH_RAHDR;
                      ra_ver_d = 16'd0;
                      entry_d  = 15'd0;
                      off_d    = 32'd0;
                    end
                  end else if (word_v == 16'd0) begin
                    go_xnext = 1'b1;
                  end else begin
                    phase_d = PH_SKIP;
                  end
                end
              end
            endcase
          end
          PH_SKIP: begin
            extra_d = extra_q - 16'd1;
            sub_d   = sub_q - 16'd1;
            if (sub_d == 16'd0) begin
              go_xnext = 1'b1;
            end
          end
          PH_RAHDR: begin
            extra_d = extra_q - 16'd1;
            sub_d   = sub_q - 16'd1;
            pos_d   = pos_q + 3'd1;
            case (pos_q)
              3'd0: ra_ver_d = {8'd0, in_byte_q};
              3'd1: ra_ver_d = {in_byte_q, ra_ver_q[7:0]};
              3'd2: clen_d = {8'd0, in_byte_q};
              3'd3: clen_d = {in_byte_q, clen_q[7:0]};
              3'd4: hold_d = in_byte_q;
              default: begin
                pos_d = 3'd0;
                if (ra_ver_q != 16'd1 || {word_v, 1'b0} != {1'b0, sub_d}) begin
                  rej = 1'b1; rej_code = gzhp_pkg::ST_BAD_RA;
                end else begin
                  ccnt_d = word_v[14:0];
                  if (word_v == 16'd0) begin
                    go_xnext = 1'b1;
                  end else begin
                    phase_d = PH_RACHUNK;
                  end
                end
              end
            endcase
          end
          PH_RACHUNK: begin
            extra_d = extra_q - 16'd1;
            sub_d   = sub_q - 16'd1;
            if (pos_q == 3'd0) begin
              hold_d = in_byte_q;
              pos_d  = 3'd1;
            end else begin
              res0.kind         = gzhp_pkg::KIND_ENTRY;
              res0.status       = gzhp_pkg::ST_OK;
              res0.entry_index  = entry_q;
              res0.entry_size   = word_v;
              res0.entry_offset = off_q;
              res_cnt = 2'd1;
              off_d   = off_q + {16'd0, word_v};
              entry_d = entry_q + 15'd1;
              pos_d   = 3'd0;
              if (sub_d == 16'd0) begin
                go_xnext = 1'b1;
              end
            end
          end
          PH_NAME: begin
            if (in_byte_q == 8'd0) begin
              go_sec = 1'b1; sec_from = 3'd2;
            end
          end
          PH_COMMENT: begin
            if (in_byte_q == 8'd0) begin
              go_sec = 1'b1; sec_from = 3'd3;
            end
          end
          PH_HCRC: begin
            if (pos_q == 3'd0) begin
              pos_d = 3'd1;
            end else begin
              go_sec = 1'b1; sec_from = 3'd4;
            end
          end
          default: phase_d = PH_DONE;
        endcase
      end
    end

    if (go_xnext) begin
      if (extra_d == 16'd0) begin
        go_sec = 1'b1; sec_from = 3'd1;
      end else if (extra_d < 16'd4) begin
        rej = 1'b1; rej_code = gzhp_pkg::ST_BAD_EXTRA;
      end else begin
        phase_d = PH_SUBHDR;
        pos_d   = 3'd0;
      end
    end

    if (go_sec) begin
      pos_d = 3'd0;
      if (sec_from == 3'd0 && flags_q[gzhp_pkg::FLG_EXTRA]) begin
        phase_d = PH_XLEN;
      end else if (sec_from <= 3'd1 && flags_q[gzhp_pkg::FLG_NAME]) begin
        phase_d = PH_NAME;
      end else if (sec_from <= 3'd2 && flags_q[gzhp_pkg::FLG_COMMENT]) begin
        phase_d = PH_COMMENT;
      end else if (sec_from <= 3'd3 && flags_q[gzhp_pkg::FLG_HCRC]) begin
        phase_d = PH_HCRC;
      end else begin
        res_new.kind                      = gzhp_pkg::KIND_ACCEPT;
        res_new.status                    = gzhp_pkg::ST_OK;
        res_new.header_length             = length_d;
        res_new.modified_time             = time_d;
        res_new.uncompressed_chunk_length = clen_d;
        res_new.chunk_total               = ccnt_d;
        phase_d = PH_DONE;
      end
    end

    if (rej) begin
      res_new        = '0;
      res_new.kind   = gzhp_pkg::KIND_REJECT;
      res_new.status = rej_code;
      phase_d        = PH_DONE;
    end

    if (rej || (go_sec && phase_d == PH_DONE)) begin
      if (res_cnt == 2'd0) begin
        res0 = res_new;
      end else begin
        res1 = res_new;
      end
      res_cnt = res_cnt + 2'd1;
    end
  end

  assign push_o.cnt = res_cnt;
  assign push_o.r0  = res0;
  assign push_o.r1  = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC1;
      pos_q    <= 3'd0;
      flags_q  <= 5'd0;
      extra_q  <= 16'd0;
      sub_q    <= 16'd0;
      id_q     <= 8'd0;
      hold_q   <= 8'd0;
      ra_ver_q <= 16'd0;
      length_q <= 32'd0;
      time_q   <= 32'd0;
      clen_q   <= 16'd0;
      ccnt_q   <= 15'd0;
      entry_q  <= 15'd0;
      off_q    <= 32'd0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      flags_q  <= flags_d;
      extra_q  <= extra_d;
      sub_q    <= sub_d;
      id_q     <= id_d;
      hold_q   <= hold_d;
      ra_ver_q <= ra_ver_d;
      length_q <= length_d;
      time_q   <= time_d;
      clen_q   <= clen_d;
      ccnt_q   <= ccnt_d;
      entry_q  <= entry_d;
      off_q    <= off_d;
    end
  end

endmodule

// ----- rtl/gzhp_res_queue.sv -----
module gzhp_res_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gzhp_pkg::push_t   push_i,
  output logic              room_o,
  gzhp_out_if.source        out_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  gzhp_pkg::res_t        slot_q [Depth];
  logic [PtrW-1:0]       wptr_q, wptr_d;
  logic [PtrW-1:0]       rptr_q, rptr_d;
  logic [PtrW:0]         count_q, count_d;
  logic [PtrW-1:0]       wptr_nx;
  logic                  pop;
  gzhp_pkg::res_t        head;

  assign pop     = out_o.valid && out_o.ready;
  assign room_o  = count_q <= (PtrW+1)'(Depth - 2);
  assign wptr_nx = wptr_q + PtrW'(1);
  assign wptr_d  = wptr_q + PtrW'(push_i.cnt);
  assign rptr_d  = rptr_q + PtrW'(pop);
  assign count_d = count_q + (PtrW+1)'(push_i.cnt) - (PtrW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      slot_q[wptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      slot_q[wptr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  assign head                          = slot_q[rptr_q];
  assign out_o.valid                   = count_q != '0;
  assign out_o.kind                    = head.kind;
  assign out_o.status                  = head.status;
  assign out_o.entry_index             = head.entry_index;
  assign out_o.entry_size              = head.entry_size;
  assign out_o.entry_offset            = head.entry_offset;
  assign out_o.header_length           = head.header_length;
  assign out_o.modified_time           = head.modified_time;
  assign out_o.uncompressed_chunk_length = head.uncompressed_chunk_length;
  assign out_o.chunk_total             = head.chunk_total;

endmodule

// ----- tb/gzip_header_parser_with_chunk_index_unit_tb.sv -----
module gzip_header_parser_with_chunk_index_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_PCT       = 37;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned STALL_CYCLES   = 150;
  localparam int unsigned FLG_TEXT       = 0;
  localparam logic [7:0]  RESERVED_FLAGS = 8'hE0;
  localparam logic [15:0] RA_VERSION     = 16'd1;

  localparam int unsigned SEC_EXTRA   = 0;
  localparam int unsigned SEC_NAME    = 1;
  localparam int unsigned SEC_COMMENT = 2;
  localparam int unsigned SEC_HCRC    = 3;
  localparam int unsigned SEC_NONE    = 4;

  typedef enum logic [3:0] {
    AT_MAGIC1, AT_MAGIC2, AT_METHOD, AT_FLAGS, AT_MTIME, AT_XFL_OS, AT_XLEN,
    AT_SUB_HDR, AT_RA_HDR, AT_RA_CHUNK, AT_SKIP, AT_NAME, AT_COMMENT, AT_HCRC,
    AT_DONE
  } parse_phase_e;

  typedef enum {
    END_ACCEPT, END_TRUNC, END_LEFTOVER, END_TOO_LONG, END_RA_SHORT, END_RA_VERSION,
    END_RA_COUNT, END_BAD_MAGIC1, END_BAD_MAGIC2, END_BAD_METHOD, END_BAD_FLAGS,
    END_EARLY_TRUNC
  } verdict_plan_e;

  logic clk_i;
  logic rst_ni;

  gzhp_in_if  in_bus ();
  gzhp_out_if out_bus ();

  gzip_header_parser_with_chunk_index_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // parser state as predicted
  parse_phase_e parse_phase;
  logic [2:0]   byte_pos;
  logic [4:0]   flags_seen;
  logic [15:0]  extra_rem;
  logic [15:0]  sub_rem;
  logic [7:0]   id_first;
  logic         sub_is_ra;
  logic [7:0]   low_hold;
  logic [15:0]  ra_ver;
  logic [31:0]  hdr_count;
  logic [31:0]  mtime_seen;
  logic [15:0]  ulen_seen;
  logic [14:0]  nchunk_seen;
  logic [14:0]  entry_idx;
  logic [31:0]  entry_off;

  gzhp_pkg::res_t expected_q[$];
  logic [7:0]     word_q[$];

  int unsigned   src_idle_pct  = IDLE_PCT;
  int unsigned   sink_idle_pct = IDLE_PCT;
  int unsigned   hold_left     = 0;
  int unsigned   extra_left    = 0;
  int unsigned   cycle_count   = 0;
  int            error_count   = 0;
  logic [7:0]    flags_sent;
  verdict_plan_e plan;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void reset_parser();
    parse_phase = AT_MAGIC1;
    byte_pos    = '0;
    flags_seen  = '0;
    extra_rem   = '0;
    sub_rem     = '0;
    id_first    = '0;
    sub_is_ra   = 1'b0;
    low_hold    = '0;
    ra_ver      = '0;
    hdr_count   = '0;
    mtime_seen  = '0;
    ulen_seen   = '0;
    nchunk_seen = '0;
    entry_idx   = '0;
    entry_off   = '0;
  endfunction

  function automatic void reject_header(logic [2:0] st);
    gzhp_pkg::res_t r;
    r        = '0;
    r.kind   = gzhp_pkg::KIND_REJECT;
    r.status = st;
    expected_q.push_back(r);
    parse_phase = AT_DONE;
  endfunction

  // move to the first optional section at or after the given one, accept if none
  function automatic void open_section(int unsigned from);
    gzhp_pkg::res_t r;
    byte_pos = '0;
    if (from <= SEC_EXTRA && flags_seen[gzhp_pkg::FLG_EXTRA]) begin
      parse_phase = AT_XLEN;
    end else if (from <= SEC_NAME && flags_seen[gzhp_pkg::FLG_NAME]) begin
      parse_phase = AT_NAME;
    end else if (from <= SEC_COMMENT && flags_seen[gzhp_pkg::FLG_COMMENT]) begin
      parse_phase = AT_COMMENT;
    end else if (from <= SEC_HCRC && flags_seen[gzhp_pkg::FLG_HCRC]) begin
      parse_phase = AT_HCRC;
    end else begin
      r                           = '0;
      r.kind                      = gzhp_pkg::KIND_ACCEPT;
      r.status                    = gzhp_pkg::ST_OK;
      r.header_length             = hdr_count;
      r.modified_time             = mtime_seen;
      r.uncompressed_chunk_length = ulen_seen;
      r.chunk_total               = nchunk_seen;
      expected_q.push_back(r);
      parse_phase = AT_DONE;
    end
  endfunction

  function automatic void next_subfield();
    if (extra_rem == 0) begin
      open_section(SEC_NAME);
    end else if (extra_rem < 4) begin
      reject_header(gzhp_pkg::ST_BAD_EXTRA);
    end else begin
      parse_phase = AT_SUB_HDR;
      byte_pos    = '0;
    end
  endfunction

  function automatic void parse_word(logic [7:0] b, logic eoi);
    gzhp_pkg::res_t r;
    logic [15:0]    v;
    if (parse_phase == AT_DONE) return;
    if (eoi) begin
      reject_header(gzhp_pkg::ST_TRUNC);
      return;
    end
    if (hdr_count != '1) hdr_count++;
    v = {b, low_hold};
    case (parse_phase)
      AT_MAGIC1: begin
        if (b != gzhp_pkg::MAGIC_ID1) reject_header(gzhp_pkg::ST_BAD_MAGIC);
        else parse_phase = AT_MAGIC2;
      end
      AT_MAGIC2: begin
        if (b != gzhp_pkg::MAGIC_ID2) reject_header(gzhp_pkg::ST_BAD_MAGIC);
        else parse_phase = AT_METHOD;
      end
      AT_METHOD: begin
        if (b != gzhp_pkg::METHOD_DEFL) reject_header(gzhp_pkg::ST_BAD_METH);
        else parse_phase = AT_FLAGS;
      end
      AT_FLAGS: begin
        if ((b & RESERVED_FLAGS) != 0) begin
          reject_header(gzhp_pkg::ST_BAD_METH);
        end else begin
          flags_seen  = b[4:0];
          parse_phase = AT_MTIME;
          byte_pos    = '0;
        end
      end
      AT_MTIME: begin
        if (byte_pos == 0) mtime_seen = {24'd0, b};
        else mtime_seen[8*byte_pos[1:0] +: 8] = b;
        if (byte_pos >= 3) begin
          parse_phase = AT_XFL_OS;
          byte_pos    = '0;
        end else begin
          byte_pos++;
        end
      end
      AT_XFL_OS: begin
        if (byte_pos == 0) byte_pos = 3'd1;
        else open_section(SEC_EXTRA);
      end
      AT_XLEN: begin
        if (byte_pos == 0) begin
          low_hold = b;
          byte_pos = 3'd1;
        end else begin
          extra_rem = v;
          next_subfield();
        end
      end
      AT_SUB_HDR: begin
        extra_rem--;
        if (byte_pos == 0) begin
          id_first = b;
          byte_pos++;
        end else if (byte_pos == 1) begin
          sub_is_ra = (id_first == gzhp_pkg::ID_R) && (b == gzhp_pkg::ID_A);
          byte_pos++;
        end else if (byte_pos == 2) begin
          low_hold = b;
          byte_pos++;
        end else if (v > extra_rem) begin
          reject_header(gzhp_pkg::ST_BAD_EXTRA);
        end else begin
          sub_rem  = v;
          byte_pos = '0;
          if (sub_is_ra) begin
            if (v < 6) begin
              reject_header(gzhp_pkg::ST_BAD_RA);
            end else begin
              parse_phase = AT_RA_HDR;
              ra_ver      = '0;
              entry_idx   = '0;
              entry_off   = '0;
            end
          end else if (v == 0) begin
            next_subfield();
          end else begin
            parse_phase = AT_SKIP;
          end
        end
      end
      AT_SKIP: begin
        extra_rem--;
        sub_rem--;
        if (sub_rem == 0) next_subfield();
      end
      AT_RA_HDR: begin
        extra_rem--;
        sub_rem--;
        if (byte_pos == 0) ra_ver = {8'd0, b};
        else if (byte_pos == 1) ra_ver[15:8] = b;
        else if (byte_pos == 2) ulen_seen = {8'd0, b};
        else if (byte_pos == 3) ulen_seen[15:8] = b;
        else if (byte_pos == 4) low_hold = b;
        if (byte_pos < 5) begin
          byte_pos++;
        end else if (ra_ver != RA_VERSION || {v, 1'b0} != {1'b0, sub_rem}) begin
          reject_header(gzhp_pkg::ST_BAD_RA);
        end else begin
          nchunk_seen = v[14:0];
          byte_pos    = '0;
          if (v == 0) next_subfield();
          else parse_phase = AT_RA_CHUNK;
        end
      end
      AT_RA_CHUNK: begin
        extra_rem--;
        sub_rem--;
        if (byte_pos == 0) begin
          low_hold = b;
          byte_pos = 3'd1;
        end else begin
          r              = '0;
          r.kind         = gzhp_pkg::KIND_ENTRY;
          r.status       = gzhp_pkg::ST_OK;
          r.entry_index  = entry_idx;
          r.entry_size   = v;
          r.entry_offset = entry_off;
          expected_q.push_back(r);
          entry_off += 32'(v);
          entry_idx++;
          byte_pos = '0;
          if (sub_rem == 0) next_subfield();
        end
      end
      AT_NAME: begin
        if (b == 0) open_section(SEC_COMMENT);
      end
      AT_COMMENT: begin
        if (b == 0) open_section(SEC_HCRC);
      end
      AT_HCRC: begin
        if (byte_pos == 0) byte_pos = 3'd1;
        else open_section(SEC_NONE);
      end
      default: parse_phase = AT_DONE;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    gzhp_pkg::res_t want;
    if (expected_q.size() == 0) begin
      $error("result word with none expected: kind %0d status %0d",
             out_bus.kind, out_bus.status);
      error_count++;
    end else begin
      want = expected_q.pop_front();
      compare_field("kind", 32'(want.kind), 32'(out_bus.kind));
      compare_field("status", 32'(want.status), 32'(out_bus.status));
      compare_field("entry_index", 32'(want.entry_index), 32'(out_bus.entry_index));
      compare_field("entry_size", 32'(want.entry_size), 32'(out_bus.entry_size));
      compare_field("entry_offset", want.entry_offset, out_bus.entry_offset);
      compare_field("header_length", want.header_length, out_bus.header_length);
      compare_field("modified_time", want.modified_time, out_bus.modified_time);
      compare_field("uncompressed_chunk_length", 32'(want.uncompressed_chunk_length),
                    32'(out_bus.uncompressed_chunk_length));
      compare_field("chunk_total", 32'(want.chunk_total), 32'(out_bus.chunk_total));
    end
  endfunction

  // result monitor
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) check_result();
    end
  end

  // result receiver, with a counted hold-off on request
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic apply_reset();
    rst_ni <= 1'b0;
    reset_parser();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic send_word(input logic [7:0] b, input logic eoi);
    if ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_bus.valid        <= 1'b1;
    in_bus.data_byte    <= b;
    in_bus.end_of_input <= eoi;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    parse_word(b, eoi);
  endtask

  task automatic send_queued();
    while (word_q.size() != 0) send_word(word_q.pop_front(), 1'b0);
  endtask

  function automatic logic [15:0] pick_u16();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic void queue_subfield_header(logic [7:0] id1, logic [7:0] id2,
                                                logic [15:0] len);
    word_q.push_back(id1);
    word_q.push_back(id2);
    word_q.push_back(len[7:0]);
    word_q.push_back(len[15:8]);
    extra_left -= 4;
  endfunction

  function automatic void queue_plain_subfield(int unsigned len, bit r_first);
    logic [7:0] id1;
    logic [7:0] id2;
    id1 = r_first ? gzhp_pkg::ID_R : 8'($urandom);
    id2 = 8'($urandom);
    if (id1 == gzhp_pkg::ID_R && id2 == gzhp_pkg::ID_A) id2 = ~gzhp_pkg::ID_A;
    queue_subfield_header(id1, id2, 16'(len));
    repeat (len) word_q.push_back(8'($urandom));
    extra_left -= len;
  endfunction

  function automatic void queue_ra_subfield(int unsigned n, logic [15:0] ver,
                                            logic [15:0] n_field, bit extremes_first);
    logic [15:0] ulen;
    logic [15:0] sz;
    ulen = pick_u16();
    queue_subfield_header(gzhp_pkg::ID_R, gzhp_pkg::ID_A, 16'(6 + 2 * n));
    word_q.push_back(ver[7:0]);
    word_q.push_back(ver[15:8]);
    word_q.push_back(ulen[7:0]);
    word_q.push_back(ulen[15:8]);
    word_q.push_back(n_field[7:0]);
    word_q.push_back(n_field[15:8]);
    for (int unsigned i = 0; i < n; i++) begin
      if (extremes_first && i == 0) sz = 16'h0000;
      else if (extremes_first && i == 1) sz = 16'hFFFF;
      else sz = pick_u16();
      word_q.push_back(sz[7:0]);
      word_q.push_back(sz[15:8]);
    end
    extra_left -= 6 + 2 * n;
  endfunction

  function automatic void queue_text();
    repeat ($urandom_range(10)) word_q.push_back(8'($urandom_range(1, 255)));
    word_q.push_back(8'h00);
  endfunction

  task automatic test_broken_header();
    logic [7:0]  b;
    int unsigned cut;
    b = 8'($urandom);
    case (plan)
      END_BAD_MAGIC1: begin
        if (b == gzhp_pkg::MAGIC_ID1) b = ~b;
        word_q.push_back(b);
      end
      END_BAD_MAGIC2: begin
        if (b == gzhp_pkg::MAGIC_ID2) b = ~b;
        word_q.push_back(gzhp_pkg::MAGIC_ID1);
        word_q.push_back(b);
      end
      END_BAD_METHOD: begin
        if (b == gzhp_pkg::METHOD_DEFL) b = ~b;
        word_q.push_back(gzhp_pkg::MAGIC_ID1);
        word_q.push_back(gzhp_pkg::MAGIC_ID2);
        word_q.push_back(b);
        word_q.push_back(8'($urandom));
      end
      END_BAD_FLAGS: begin
        word_q.push_back(gzhp_pkg::MAGIC_ID1);
        word_q.push_back(gzhp_pkg::MAGIC_ID2);
        word_q.push_back(gzhp_pkg::METHOD_DEFL);
        word_q.push_back(b | (8'h20 << $urandom_range(2)));
      end
      default: begin
        word_q.push_back(gzhp_pkg::MAGIC_ID1);
        word_q.push_back(gzhp_pkg::MAGIC_ID2);
        word_q.push_back(gzhp_pkg::METHOD_DEFL);
        word_q.push_back(8'($urandom_range(31)));
        repeat (6) word_q.push_back(8'($urandom));
        cut = $urandom_range(word_q.size());
        while (word_q.size() > cut) void'(word_q.pop_back());
      end
    endcase
    send_queued();
    if (plan == END_EARLY_TRUNC) send_word(8'($urandom), 1'b1);
  endtask

  task automatic test_header_fields();
    logic [31:0] mtime;
    logic [15:0] xlen;
    int unsigned sel;
    flags_sent = '0;
    flags_sent[gzhp_pkg::FLG_EXTRA]   = 1'b1;
    flags_sent[FLG_TEXT]              = $urandom_range(1);
    flags_sent[gzhp_pkg::FLG_NAME]    = ($urandom_range(3) != 0);
    flags_sent[gzhp_pkg::FLG_COMMENT] = ($urandom_range(3) != 0);
    flags_sent[gzhp_pkg::FLG_HCRC]    = ($urandom_range(3) != 0);
    sel = $urandom_range(2);
    mtime = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
    xlen = 16'(600 + $urandom_range(60));
    extra_left = 32'(xlen);
    word_q.push_back(gzhp_pkg::MAGIC_ID1);
    word_q.push_back(gzhp_pkg::MAGIC_ID2);
    word_q.push_back(gzhp_pkg::METHOD_DEFL);
    word_q.push_back(flags_sent);
    for (int i = 0; i < 4; i++) word_q.push_back(mtime[8*i +: 8]);
    word_q.push_back(8'($urandom));
    word_q.push_back(8'($urandom));
    word_q.push_back(xlen[7:0]);
    word_q.push_back(xlen[15:8]);
    send_queued();
  endtask

  task automatic test_directed_subfields();
    // empty subfield, R with a non-A second id, empty RA table, RA table with extreme sizes
    queue_plain_subfield(0, 1'b0);
    queue_plain_subfield(1, 1'b1);
    queue_ra_subfield(0, RA_VERSION, 16'd0, 1'b0);
    queue_ra_subfield(2, RA_VERSION, 16'd2, 1'b1);
    send_queued();
  endtask

  task automatic test_output_stall();
    src_idle_pct = 0;
    hold_left    = STALL_CYCLES;
    queue_ra_subfield(24, RA_VERSION, 16'd24, 1'b0);
    send_queued();
    src_idle_pct = IDLE_PCT;
  endtask

  task automatic test_drain_pause();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic test_random_subfields();
    int unsigned room;
    int unsigned pick;
    int unsigned n;
    int unsigned fast_from;
    int unsigned idx;
    fast_from = $urandom_range(10);
    idx = 0;
    while (extra_left > 40) begin
      room = extra_left - 10;
      if (idx == fast_from) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (idx == fast_from + 8) begin
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
      end
      pick = $urandom_range(9);
      if (pick < 5) begin
        n = $urandom_range(((room - 10) / 2 < 12) ? (room - 10) / 2 : 12);
        queue_ra_subfield(n, RA_VERSION, 16'(n), 1'b0);
      end else begin
        queue_plain_subfield($urandom_range((room - 4 < 20) ? room - 4 : 20), pick == 9);
      end
      send_queued();
      idx++;
    end
    src_idle_pct  = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;
  endtask

  task automatic test_header_verdict();
    int unsigned left;
    int unsigned n;
    int unsigned cut;
    logic [15:0] ver;
    left = extra_left;
    n    = $urandom_range((left - 10) / 2);
    case (plan)
      END_LEFTOVER: queue_plain_subfield(left - 4 - $urandom_range(1, 3), 1'b0);
      END_TOO_LONG: begin
        queue_subfield_header(8'($urandom), 8'($urandom),
                              16'($urandom_range(left - 3, 16'hFFFF)));
      end
      END_RA_SHORT: queue_subfield_header(gzhp_pkg::ID_R, gzhp_pkg::ID_A,
                                          16'($urandom_range(5)));
      END_RA_VERSION: begin
        ver = 16'($urandom);
        if (ver == RA_VERSION) ver = 16'd0;
        queue_ra_subfield(n, ver, 16'(n), 1'b0);
      end
      END_RA_COUNT: begin
        queue_ra_subfield(n, RA_VERSION, 16'(n) ^ 16'($urandom_range(1, 16'hFFFF)), 1'b0);
      end
      default: begin
        // close the extra field exactly, then the trailing sections, cut short for a truncation
        if (left % 2 == 0) queue_ra_subfield((left - 10) / 2, RA_VERSION,
                                             16'((left - 10) / 2), 1'b0);
        else queue_plain_subfield(left - 4, 1'b0);
        if (flags_sent[gzhp_pkg::FLG_NAME]) queue_text();
        if (flags_sent[gzhp_pkg::FLG_COMMENT]) queue_text();
        if (flags_sent[gzhp_pkg::FLG_HCRC]) begin
          word_q.push_back(8'($urandom));
          word_q.push_back(8'($urandom));
        end
        if (plan == END_TRUNC) begin
          cut = $urandom_range(word_q.size() - 1);
          while (word_q.size() > cut) void'(word_q.pop_back());
        end
      end
    endcase
    send_queued();
    if (plan == END_TRUNC) send_word(8'($urandom), 1'b1);
  endtask

  task automatic test_ignored_after_verdict();
    repeat (24) send_word(8'($urandom), $urandom_range(3) == 0);
    in_bus.valid <= 1'b0;
  endtask

  initial begin
    int unsigned r;
    in_bus.valid        <= 1'b0;
    in_bus.data_byte    <= 8'h00;
    in_bus.end_of_input <= 1'b0;
    apply_reset();

    // optionally a broken header runs first on its own, then the block is reset for a full file
    r = $urandom_range(99);
    if (r >= 92) begin
      plan = verdict_plan_e'(int'(END_BAD_MAGIC1) + int'($urandom_range(4)));
      test_broken_header();
      test_ignored_after_verdict();
      do @(posedge clk_i); while (expected_q.size() != 0);
      apply_reset();
      r = $urandom_range(91);
    end
    if (r < 44) plan = END_ACCEPT;
    else if (r < 56) plan = END_TRUNC;
    else if (r < 64) plan = END_LEFTOVER;
    else if (r < 72) plan = END_TOO_LONG;
    else if (r < 78) plan = END_RA_SHORT;
    else if (r < 85) plan = END_RA_VERSION;
    else plan = END_RA_COUNT;

    test_header_fields();
    test_directed_subfields();
    test_output_stall();
    test_drain_pause();
    test_random_subfields();
    test_header_verdict();
    test_ignored_after_verdict();

    do @(posedge clk_i); while (expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
